// ===== sv/sstt_pkg.sv =====
package sstt_pkg;

   localparam int SLOTS            = 8192;
   localparam int PAGE_BYTES       = 4096;
   localparam int SECTORS_PER_PAGE = 8;

   localparam int SLOT_W     = 13;
   localparam int LEN_W      = 13;
   localparam int SECTOR_W   = 49;
   localparam int BASE_W     = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;

   localparam int TBL_AW   = $clog2(SLOTS);
   localparam int MAP_BITS = 64;
   localparam int BIT_W    = $clog2(MAP_BITS);
   localparam int WORDS    = SLOTS / MAP_BITS;
   localparam int WORD_W   = $clog2(WORDS);
   localparam int GRP_SIZE = 16;
   localparam int GIDX_W   = $clog2(GRP_SIZE);
   localparam int GRPS     = WORDS / GRP_SIZE;
   localparam int GSEL_W   = $clog2(GRPS);

   localparam logic [1:0] OP_STORE   = 2'd0;
   localparam logic [1:0] OP_RESTORE = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [2:0] STAT_OK   = 3'd0;
   localparam logic [2:0] STAT_FULL = 3'd1;
   localparam logic [2:0] STAT_OOM  = 3'd2;
   localparam logic [2:0] STAT_BAD  = 3'd3;
   localparam logic [2:0] STAT_XFER = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DISK_PRESENT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_BASE    = 1'd1;

   typedef enum logic [1:0] {
      KIND_FREE = 2'd0,
      KIND_RAM  = 2'd1,
      KIND_ZERO = 2'd2,
      KIND_DISK = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [SLOT_W-1:0] slot;
      logic              page_all_zero;
      logic [11:0]       packed_len;
      logic              blob_alloc_ok;
      logic              disk_write_ok;
      logic              raw_alloc_ok;
      logic              transfer_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [SLOT_W-1:0]   slot_used;
      logic [1:0]          tier;
      logic [LEN_W-1:0]    stored_len;
      logic [SECTOR_W-1:0] disk_sector;
      logic [13:0]         resident_pages;
      logic [31:0]         pages_out;
      logic [31:0]         pages_in;
      logic [13:0]         ram_pages;
      logic [25:0]         ram_bytes;
   } rsp_type;

   typedef struct packed {
      logic              search;
      logic              rd;
      logic [WORD_W-1:0] rd_word;
      logic              wr;
      logic [WORD_W-1:0] wr_word;
      logic [BIT_W-1:0]  wr_bit;
      logic              wr_free;
      logic              init;
      logic [WORD_W-1:0] init_word;
   } map_ctl_type;

   typedef struct packed {
      logic              found;
      logic [WORD_W-1:0] word;
      logic [BIT_W-1:0]  bit_idx;
   } map_stat_type;

endpackage

// ===== sv/swap_slot_tier_table_core.sv =====
// channel  ports                          moves
// req      req_valid, req_stall, req_word  one operation word in
// rsp      rsp_valid, rsp_stall, rsp_word  one result word out
// csr      csr_wen, csr_index, csr_wdata   register writes, no wait
//
// Store steps through accept, free word search, and bit pick and commit;
// restore and release step through accept, then table read and commit.
// Both memories (slot table and free bitmap) have registered reads.
// After reset a clearing pass writes the slot table and the free bitmap;
// req_stall is high during it.
// A stalled result holds the commit until the output register drains.
module swap_slot_tier_table_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sstt_pkg::req_type                   req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sstt_pkg::rsp_type                   rsp_word,
   input  logic                                csr_wen,
   input  logic [sstt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sstt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sstt_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_LOOK  = 4'b0100,
      S_PICK  = 4'b1000
   } state_type;

   localparam logic [SECTOR_W-1:0] SECTOR_MUL = SECTOR_W'(SECTORS_PER_PAGE);

   state_type           state_ff, state_in;
   logic [TBL_AW-1:0]   clr_ff, clr_in;
   req_type             req_ff;
   entry_type           tbl [SLOTS];
   entry_type           tbl_rd_ff;
   logic                tbl_we;
   logic [TBL_AW-1:0]   tbl_waddr;
   entry_type           tbl_wdata;
   logic                disk_present_ff;
   logic [BASE_W-1:0]   disk_base_ff;
   logic [13:0]         resident_ff, resident_in;
   logic [31:0]         out_ff, out_in;
   logic [31:0]         in_ff, in_in;
   logic [13:0]         rpages_ff, rpages_in;
   logic [25:0]         rbytes_ff, rbytes_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   rsp_type             res;
   logic                commit;
   logic                out_free;
   logic                accept;
   map_ctl_type         mctl;
   map_stat_type        mstat;
   logic [SLOT_W-1:0]   slot_new;
   logic [SLOT_W-1:0]   sec_slot;
   logic [SECTOR_W-1:0] sector;
   logic                in_range;
   logic                xfer_good;
   kind_type            st_kind;
   logic [LEN_W-1:0]    st_len;
   logic [2:0]          st_stat;

   sstt_free_map u_map (
      .clock    (clock),
      .reset    (reset),
      .map_ctl  (mctl),
      .map_stat (mstat)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_new  = SLOT_W'({mstat.word, mstat.bit_idx});
   assign sec_slot  = (state_ff == S_PICK) ? slot_new : req_ff.slot;
   assign sector    = {1'b0, disk_base_ff} + (SECTOR_W'(sec_slot) * SECTOR_MUL);
   assign in_range  = ({1'b0, req_ff.slot} < (SLOT_W + 1)'(SLOTS));

   always_comb begin
      st_kind = KIND_ZERO;
      st_len  = '0;
      st_stat = STAT_OK;
      if (!mstat.found) begin
         st_stat = STAT_FULL;
      end else if (req_ff.page_all_zero) begin
         st_kind = KIND_ZERO;
      end else if ((req_ff.packed_len != '0) &&
                   ({1'b0, req_ff.packed_len} < LEN_W'(PAGE_BYTES)) &&
                   req_ff.blob_alloc_ok) begin
         st_kind = KIND_RAM;
         st_len  = LEN_W'(req_ff.packed_len);
      end else if (disk_present_ff && req_ff.disk_write_ok) begin
         st_kind = KIND_DISK;
      end else if (req_ff.raw_alloc_ok) begin
         st_kind = KIND_RAM;
         st_len  = LEN_W'(PAGE_BYTES);
      end else begin
         st_stat = STAT_OOM;
      end
   end

   always_comb begin
      xfer_good = 1'b0;
      case (tbl_rd_ff.kind)
         KIND_ZERO: xfer_good = 1'b1;
         KIND_RAM:  xfer_good = (tbl_rd_ff.len >= LEN_W'(PAGE_BYTES)) || req_ff.transfer_ok;
         KIND_DISK: xfer_good = disk_present_ff && req_ff.transfer_ok;
         default:   xfer_good = 1'b0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      commit      = 1'b0;
      tbl_we      = 1'b0;
      tbl_waddr   = clr_ff;
      tbl_wdata   = '0;
      mctl        = '0;
      resident_in = resident_ff;
      out_in      = out_ff;
      in_in       = in_ff;
      rpages_in   = rpages_ff;
      rbytes_in   = rbytes_ff;
      res         = '0;
      res.status  = STAT_BAD;
      case (state_ff)
         S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            if (clr_ff < TBL_AW'(WORDS)) begin
               mctl.init      = 1'b1;
               mctl.init_word = clr_ff[WORD_W-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == TBL_AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            mctl.rd      = 1'b1;
            mctl.rd_word = req_word.slot[TBL_AW-1:BIT_W];
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (req_ff.op == OP_STORE) begin
               mctl.search = 1'b1;
               state_in    = S_PICK;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
               if (req_ff.op inside {OP_RESTORE, OP_RELEASE}) begin
                  res.slot_used = req_ff.slot;
                  if (in_range && (tbl_rd_ff.kind != KIND_FREE)) begin
                     res.tier       = tbl_rd_ff.kind;
                     res.stored_len = tbl_rd_ff.len;
                     if (tbl_rd_ff.kind == KIND_DISK) begin
                        res.disk_sector = sector;
                     end
                     if (req_ff.op == OP_RESTORE) begin
                        if (xfer_good) begin
                           res.status = STAT_OK;
                           in_in      = in_ff + 1'b1;
                        end else begin
                           res.status = STAT_XFER;
                        end
                     end else begin
                        res.status = STAT_OK;
                        if (tbl_rd_ff.kind == KIND_RAM) begin
                           rbytes_in = rbytes_ff - 26'(tbl_rd_ff.len);
                           rpages_in = rpages_ff - 1'b1;
                        end
                        resident_in  = resident_ff - 1'b1;
                        tbl_we       = 1'b1;
                        tbl_waddr    = req_ff.slot[TBL_AW-1:0];
                        tbl_wdata    = '0;
                        mctl.wr      = 1'b1;
                        mctl.wr_word = req_ff.slot[TBL_AW-1:BIT_W];
                        mctl.wr_bit  = req_ff.slot[BIT_W-1:0];
                        mctl.wr_free = 1'b1;
                     end
                  end
               end
            end
         end
         S_PICK: begin
            if (out_free) begin
               commit     = 1'b1;
               state_in   = S_IDLE;
               res.status = st_stat;
               if (st_stat == STAT_OK) begin
                  res.slot_used  = slot_new;
                  res.tier       = st_kind;
                  res.stored_len = st_len;
                  if (st_kind == KIND_DISK) begin
                     res.disk_sector = sector;
                  end
                  tbl_we          = 1'b1;
                  tbl_waddr       = slot_new[TBL_AW-1:0];
                  tbl_wdata.kind  = st_kind;
                  tbl_wdata.len   = st_len;
                  mctl.wr         = 1'b1;
                  mctl.wr_word    = mstat.word;
                  mctl.wr_bit     = mstat.bit_idx;
                  mctl.wr_free    = 1'b0;
                  out_in          = out_ff + 1'b1;
                  resident_in     = resident_ff + 1'b1;
                  if (st_kind == KIND_RAM) begin
                     rpages_in = rpages_ff + 1'b1;
                     rbytes_in = rbytes_ff + 26'(st_len);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      res.resident_pages = resident_in;
      res.pages_out      = out_in;
      res.pages_in       = in_in;
      res.ram_pages      = rpages_in;
      res.ram_bytes      = rbytes_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl[tbl_waddr] <= tbl_wdata;
      end
      if (state_ff == S_IDLE) begin
         tbl_rd_ff <= tbl[req_word.slot[TBL_AW-1:0]];
      end
      if (accept) begin
         req_ff <= req_word;
      end
      if (commit) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         disk_present_ff <= 1'b0;
         disk_base_ff    <= '0;
         resident_ff     <= '0;
         out_ff          <= '0;
         in_ff           <= '0;
         rpages_ff       <= '0;
         rbytes_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         resident_ff <= resident_in;
         out_ff      <= out_in;
         in_ff       <= in_in;
         rpages_ff   <= rpages_in;
         rbytes_ff   <= rbytes_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_DISK_PRESENT: disk_present_ff <= csr_wdata[0];
               CSR_DISK_BASE:    disk_base_ff    <= csr_wdata[BASE_W-1:0];
               default:          ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit while result register is held");

   a_resident_max: assert property (@(posedge clock) disable iff (reset)
      resident_ff <= 14'(SLOTS))
      else $error("resident count above slot count");

   a_ram_le_resident: assert property (@(posedge clock) disable iff (reset)
      rpages_ff <= resident_ff)
      else $error("ram page count above resident count");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result word during clearing pass");
`endif

endmodule

// ===== sv/sstt_free_map.sv =====
module sstt_free_map (
   input  logic                  clock,
   input  logic                  reset,
   input  sstt_pkg::map_ctl_type map_ctl,
   output sstt_pkg::map_stat_type map_stat
);
   import sstt_pkg::*;

   logic [MAP_BITS-1:0] mem [WORDS];
   logic [WORDS-1:0]    any_ff;
   logic [GRPS-1:0]     grp_hit_ff;
   logic [GRPS-1:0]     grp_hit_in;
   logic [GIDX_W-1:0]   grp_idx_ff [GRPS];
   logic [GIDX_W-1:0]   grp_idx_in [GRPS];
   logic [MAP_BITS-1:0] rd_data_ff;
   logic                found_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [GSEL_W-1:0]   grp_sel;
   logic [WORD_W-1:0]   search_word;
   logic                search_hit;
   logic [WORD_W-1:0]   rd_addr;
   logic [BIT_W-1:0]    low_bit;
   logic [MAP_BITS-1:0] new_word;

   always_comb begin
      for (int g = 0; g < GRPS; g++) begin
         grp_hit_in[g] = |any_ff[g*GRP_SIZE +: GRP_SIZE];
         grp_idx_in[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (any_ff[g*GRP_SIZE + b]) begin
               grp_idx_in[g] = GIDX_W'(b);
            end
         end
      end
   end

   always_comb begin
      grp_sel = '0;
      for (int g = GRPS - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            grp_sel = GSEL_W'(g);
         end
      end
      search_word = {grp_sel, grp_idx_ff[grp_sel]};
      search_hit  = |grp_hit_ff;
      rd_addr     = map_ctl.search ? search_word : map_ctl.rd_word;
   end

   always_comb begin
      low_bit = '0;
      for (int b = MAP_BITS - 1; b >= 0; b--) begin
         if (rd_data_ff[b]) begin
            low_bit = BIT_W'(b);
         end
      end
      new_word                 = rd_data_ff;
      new_word[map_ctl.wr_bit] = map_ctl.wr_free;
   end

   always_ff @(posedge clock) begin
      if (map_ctl.init) begin
         mem[map_ctl.init_word] <= '1;
      end else if (map_ctl.wr) begin
         mem[map_ctl.wr_word] <= new_word;
      end
      if (map_ctl.search || map_ctl.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (map_ctl.search) begin
         word_ff <= search_word;
      end
      for (int g = 0; g < GRPS; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff     <= '1;
         grp_hit_ff <= '0;
         found_ff   <= 1'b0;
      end else begin
         grp_hit_ff <= grp_hit_in;
         if (map_ctl.wr) begin
            any_ff[map_ctl.wr_word] <= |new_word;
         end
         if (map_ctl.search) begin
            found_ff <= search_hit;
         end
      end
   end

   assign map_stat.found   = found_ff;
   assign map_stat.word    = word_ff;
   assign map_stat.bit_idx = low_bit;

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sstt_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LIMIT       = 1500000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 16;

   typedef enum {PACE_FREE, PACE_RANDOM, PACE_PERIODIC, PACE_HOLD} pace_type;

   class slot_table_board;
      kind_type          kind_of [SLOTS];
      logic [LEN_W-1:0]  len_of [SLOTS];
      int                first_free;
      int                peak;
      bit                disk_on;
      logic [BASE_W-1:0] disk_base;
      logic [13:0]       resident;
      logic [31:0]       outs;
      logic [31:0]       ins;
      logic [13:0]       ram_pages;
      logic [25:0]       ram_bytes;
      rsp_type           replies_due [$];
      int                mismatches;

      function new();
         foreach (kind_of[i]) begin
            kind_of[i] = KIND_FREE;
            len_of[i]  = '0;
         end
         first_free = 0;
         peak       = 0;
         disk_on    = 1'b0;
         disk_base  = '0;
         resident   = '0;
         outs       = '0;
         ins        = '0;
         ram_pages  = '0;
         ram_bytes  = '0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DISK_PRESENT)
            disk_on = data[0];
         else
            disk_base = data[BASE_W-1:0];
      endfunction

      function int outstanding();
         return replies_due.size();
      endfunction

      function int lowest_free();
         int s;
         s = first_free;
         while (s < SLOTS && kind_of[s] != KIND_FREE)
            s++;
         first_free = s;
         return (s < SLOTS) ? s : -1;
      endfunction

      function logic [SECTOR_W-1:0] sector_of(int s);
         return SECTOR_W'(disk_base) + SECTOR_W'(s) * SECTOR_W'(SECTORS_PER_PAGE);
      endfunction

      function void take_request(req_type r);
         rsp_type          e;
         int               s;
         kind_type         k;
         logic [LEN_W-1:0] len;
         bit               ok;
         e = '0;
         e.status = STAT_BAD;
         len = '0;
         k = KIND_FREE;
         case (r.op)
            OP_STORE: begin
               s = lowest_free();
               if (s < 0) begin
                  e.status = STAT_FULL;
               end else begin
                  e.status = STAT_OK;
                  if (r.page_all_zero) begin
                     k = KIND_ZERO;
                  end else if (r.packed_len != 0 && r.blob_alloc_ok) begin
                     k = KIND_RAM;
                     len = LEN_W'(r.packed_len);
                  end else if (disk_on && r.disk_write_ok) begin
                     k = KIND_DISK;
                  end else if (r.raw_alloc_ok) begin
                     k = KIND_RAM;
                     len = LEN_W'(PAGE_BYTES);
                  end else begin
                     e.status = STAT_OOM;
                  end
                  if (e.status == STAT_OK) begin
                     kind_of[s] = k;
                     len_of[s] = len;
                     first_free = s + 1;
                     if (s > peak)
                        peak = s;
                     resident = resident + 1'b1;
                     outs = outs + 1'b1;
                     if (k == KIND_RAM) begin
                        ram_pages = ram_pages + 1'b1;
                        ram_bytes = ram_bytes + len;
                     end
                     e.slot_used = SLOT_W'(s);
                     e.tier = k;
                     e.stored_len = len;
                     if (k == KIND_DISK)
                        e.disk_sector = sector_of(s);
                  end
               end
            end
            OP_RESTORE, OP_RELEASE: begin
               s = int'(r.slot);
               e.slot_used = r.slot;
               k = kind_of[s];
               if (k != KIND_FREE) begin
                  len = len_of[s];
                  e.tier = k;
                  e.stored_len = len;
                  if (k == KIND_DISK)
                     e.disk_sector = sector_of(s);
                  if (r.op == OP_RESTORE) begin
                     case (k)
                        KIND_ZERO: ok = 1'b1;
                        KIND_RAM:  ok = (len >= PAGE_BYTES) || r.transfer_ok;
                        default:   ok = disk_on && r.transfer_ok;
                     endcase
                     if (ok) begin
                        e.status = STAT_OK;
                        ins = ins + 1'b1;
                     end else begin
                        e.status = STAT_XFER;
                     end
                  end else begin
                     e.status = STAT_OK;
                     if (k == KIND_RAM) begin
                        ram_bytes = ram_bytes - len;
                        ram_pages = ram_pages - 1'b1;
                     end
                     kind_of[s] = KIND_FREE;
                     len_of[s] = '0;
                     resident = resident - 1'b1;
                     if (s < first_free)
                        first_free = s;
                  end
               end
            end
            default: ;
         endcase
         e.resident_pages = resident;
         e.pages_out = outs;
         e.pages_in = ins;
         e.ram_pages = ram_pages;
         e.ram_bytes = ram_bytes;
         replies_due.push_back(e);
      endfunction

      function void compare(string name, logic [63:0] exp, logic [63:0] act);
         if (act !== exp) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatches++;
         end
      endfunction

      function void match_reply(rsp_type got);
         rsp_type e;
         if (replies_due.size() == 0) begin
            $error("reply with nothing due: status %0d slot %0d", got.status, got.slot_used);
            mismatches++;
         end else begin
            e = replies_due.pop_front();
            compare("status", e.status, got.status);
            compare("slot_used", e.slot_used, got.slot_used);
            compare("tier", e.tier, got.tier);
            compare("stored_len", e.stored_len, got.stored_len);
            compare("disk_sector", e.disk_sector, got.disk_sector);
            compare("resident_pages", e.resident_pages, got.resident_pages);
            compare("pages_out", e.pages_out, got.pages_out);
            compare("pages_in", e.pages_in, got.pages_in);
            compare("ram_pages", e.ram_pages, got.ram_pages);
            compare("ram_bytes", e.ram_bytes, got.ram_bytes);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_word;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bit                    hold_wanted;
   bit                    hold_done;
   int                    cycles;

   slot_table_board board = new();

   swap_slot_tier_table_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.take_request(req_word);
      if (!reset && rsp_valid && !rsp_stall)
         board.match_reply(rsp_word);
   end

   initial begin : reply_pacer
      int       span;
      int       pct;
      int       period;
      int       n;
      pace_type mode;
      rsp_stall = 1'b0;
      forever begin
         mode   = pace_type'($urandom_range(0, 2));
         span   = $urandom_range(16, 160);
         pct    = $urandom_range(10, 85);
         period = $urandom_range(2, 5);
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            mode = PACE_HOLD;
            span = HOLD_CYCLES;
         end
         for (n = 0; n < span; n++) begin
            @(posedge clock);
            case (mode)
               PACE_FREE:     rsp_stall <= 1'b0;
               PACE_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < pct);
               PACE_PERIODIC: rsp_stall <= (n % period == 0);
               default:       rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   initial begin : watchdog
      cycles = 0;
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type mk(logic [1:0] op, int slot, bit zero, int plen,
                                  bit blob, bit disk, bit raw, bit xfer);
      req_type w;
      w.op = op;
      w.slot = SLOT_W'(slot);
      w.page_all_zero = zero;
      w.packed_len = 12'(plen);
      w.blob_alloc_ok = blob;
      w.disk_write_ok = disk;
      w.raw_alloc_ok = raw;
      w.transfer_ok = xfer;
      return w;
   endfunction

   function automatic req_type pick_request(bit stores_only);
      req_type w;
      int      roll;
      int      top;
      w = $urandom;
      roll = stores_only ? 0 : $urandom_range(0, 99);
      top = (board.peak + 2 > SLOTS - 1) ? SLOTS - 1 : board.peak + 2;
      if (roll < 40) begin
         w.op = OP_STORE;
         w.page_all_zero = ($urandom_range(0, 9) == 0);
         case ($urandom_range(0, 9))
            0: w.packed_len = '0;
            1: w.packed_len = '1;
            default: ;
         endcase
         w.blob_alloc_ok = ($urandom_range(0, 3) != 0);
         w.raw_alloc_ok = ($urandom_range(0, 7) != 0);
         if (stores_only) begin
            if ($urandom_range(0, 9) < 6)
               w.packed_len = '0;
            w.raw_alloc_ok = 1'b1;
         end
      end else if (roll < 95) begin
         w.op = (roll < 70) ? OP_RESTORE : OP_RELEASE;
         if ($urandom_range(0, 6) != 0)
            w.slot = SLOT_W'($urandom_range(0, top));
         w.transfer_ok = ($urandom_range(0, 3) != 0);
      end else begin
         w.op = OP_UNUSED;
      end
      return w;
   endfunction

   task automatic offer(input req_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.set_reg(idx, data);
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_disk(input bit on, input logic [BASE_W-1:0] base);
      write_reg(CSR_DISK_PRESENT, CSR_DATA_W'(on));
      write_reg(CSR_DISK_BASE, CSR_DATA_W'(base));
   endtask

   task automatic random_run(input int count, input bit stores_only);
      int sent;
      int burst;
      int k;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 12);
         for (k = 0; k < burst && sent < count; k++) begin
            offer(pick_request(stores_only));
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_wen   = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_disk(1'b1, {BASE_W{1'b1}});
      offer(mk(OP_STORE,   0,    1, 0,    0, 0, 0, 0));
      offer(mk(OP_STORE,   8191, 0, 1,    1, 0, 0, 0));
      offer(mk(OP_STORE,   0,    0, 4095, 1, 1, 1, 0));
      offer(mk(OP_STORE,   0,    0, 0,    1, 1, 1, 0));
      offer(mk(OP_STORE,   0,    0, 77,   0, 0, 1, 0));
      offer(mk(OP_STORE,   0,    0, 0,    1, 0, 0, 1));
      offer(mk(OP_STORE,   0,    0, 4095, 0, 1, 0, 0));
      offer(mk(OP_RESTORE, 0,    0, 0,    0, 0, 0, 0));
      offer(mk(OP_RESTORE, 1,    0, 0,    0, 0, 0, 0));
      offer(mk(OP_RESTORE, 1,    0, 0,    0, 0, 0, 1));
      offer(mk(OP_RESTORE, 4,    0, 0,    0, 0, 0, 0));
      offer(mk(OP_RESTORE, 3,    0, 0,    0, 0, 0, 0));
      offer(mk(OP_RESTORE, 3,    0, 0,    0, 0, 0, 1));
      offer(mk(OP_RELEASE, 2,    0, 0,    0, 0, 0, 0));
      offer(mk(OP_RELEASE, 2,    0, 0,    0, 0, 0, 0));
      offer(mk(OP_RESTORE, 2,    0, 0,    0, 0, 0, 1));
      offer(mk(OP_RESTORE, 8191, 1, 4095, 1, 1, 1, 1));
      offer(mk(OP_RELEASE, 8191, 1, 4095, 1, 1, 1, 1));
      offer(mk(OP_UNUSED,  8191, 1, 4095, 1, 1, 1, 1));
      offer(mk(OP_STORE,   8191, 1, 4095, 1, 1, 1, 1));
      drain();

      // disk tier gone: disk slots can no longer be read back
      set_disk(1'b0, {BASE_W{1'b1}});
      offer(mk(OP_RESTORE, 5, 0, 0, 0, 0, 0, 1));
      offer(mk(OP_STORE,   0, 0, 0, 1, 1, 1, 0));
      offer(mk(OP_RELEASE, 5, 0, 0, 0, 0, 0, 0));
      offer(mk(OP_RELEASE, 1, 0, 0, 0, 0, 0, 0));
      drain();

      set_disk(1'b1, BASE_W'({$urandom, $urandom}));
      hold_wanted = 1'b1;
      random_run(250, 1'b0);
      drain();

      set_disk(1'b0, BASE_W'({$urandom, $urandom}));
      random_run(250, 1'b0);
      drain();

      set_disk(1'b1, '0);
      random_run(250, 1'b0);
      drain();

      set_disk(1'b1, {BASE_W{1'b1}});
      random_run(250, 1'b0);
      drain();

      // store-heavy run to raise occupancy, then churn across it
      set_disk(1'b1, '0);
      random_run(150, 1'b1);
      random_run(100, 1'b0);
      drain();

      if (board.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
